/* hdl/duplicate_event_suppressor_assert.svh */
// Assertion macros for the duplicate event suppressor.
// Expects clk_i and rst_ni in the scope of the module that includes it.
`ifndef DUPLICATE_EVENT_SUPPRESSOR_ASSERT_SVH
`define DUPLICATE_EVENT_SUPPRESSOR_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define DSUP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define DSUP_ASSERT_NEVER(lbl, expr, msg) \
  `DSUP_ASSERT(lbl, !(expr), msg)

`endif

/* hdl/dsup_pkg.sv */
// Shared widths, codes and types of the duplicate event suppressor.
// No dependencies.
package dsup_pkg;

  localparam int unsigned HashW    = 64;
  localparam int unsigned LevelW   = 3;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 48;

  // Table depth and command queue depth
  localparam int unsigned Entries    = 10;
  localparam int unsigned QueueDepth = 2;

  // Register reset values and notice level
  localparam logic [TimeW-1:0]  WindowReset = TimeW'(5000000);
  localparam logic [LevelW-1:0] LevelReset  = LevelW'(4);
  localparam logic [LevelW-1:0] NoticeLevel = LevelW'(1);
  localparam logic [CountW-1:0] CountMax    = '1;

  typedef enum logic [CfgAddrW-1:0] {
    CfgWindow   = 2'd0,
    CfgMinLevel = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FrIdle,
    FrCmp,
    FrUpd
  } front_state_e;

  // Command from the classifier to the output sequencer
  typedef struct packed {
    logic              notice;
    logic [CountW-1:0] count;
    logic [HashW-1:0]  hash;
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  stamp;
  } dsup_cmd_t;

endpackage

/* hdl/dsup_if.sv */
// Handshake channels of the duplicate event suppressor: event in, result out, config.
// Depends on dsup_pkg.
interface dsup_in_if import dsup_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HashW-1:0]  message_hash;
  logic [LevelW-1:0] level;
  logic [TimeW-1:0]  timestamp_us;

  modport source (output valid, message_hash, level, timestamp_us, input ready);
  modport sink   (input valid, message_hash, level, timestamp_us, output ready);
endinterface

interface dsup_out_if import dsup_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_skip_notice;
  logic [CountW-1:0] skipped_count;
  logic [HashW-1:0]  out_hash;
  logic [LevelW-1:0] out_level;
  logic [TimeW-1:0]  out_time_us;
  logic              last;

  modport source (output valid, is_skip_notice, skipped_count, out_hash, out_level,
                  out_time_us, last, input ready);
  modport sink   (input valid, is_skip_notice, skipped_count, out_hash, out_level,
                  out_time_us, last, output ready);
endinterface

interface dsup_cfg_if import dsup_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [CfgDataW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* hdl/dsup_fifo.sv */
// Short command queue between the classifier and the output sequencer.
// Depends on dsup_pkg.
module dsup_fifo import dsup_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dsup_cmd_t push_cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output dsup_cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dsup_cmd_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap, track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* hdl/dsup_front.sv */
// Classifier: takes events and config writes, keeps the recent-event list and skip count,
// and queues commands for forwarded events. Depends on dsup_pkg and dsup_if.
module dsup_front import dsup_pkg::*; #(
  parameter int unsigned NumEntries = Entries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsup_in_if.sink   in_i,
  dsup_cfg_if.sink  cfg_i,
  output logic      push_o,
  output dsup_cmd_t push_cmd_o,
  input  logic      full_i
);

  front_state_e state_q, state_d;

  logic [TimeW-1:0]  window_q;
  logic [LevelW-1:0] min_level_q;

  logic [HashW-1:0]  hash_q;
  logic [LevelW-1:0] level_q;
  logic [TimeW-1:0]  stamp_q;

  logic [HashW-1:0]  ent_hash_q [NumEntries];
  logic [TimeW-1:0]  ent_time_q [NumEntries];
  logic [CountW-1:0] skip_q;

  logic [NumEntries-1:0] eq_q, ok_q, eq_d, ok_d;
  logic [NumEntries-1:0] first_oh, upto_first;
  logic                  seen, hit, checked, dropped, commit, accept;
  logic [HashW-1:0]      sel_hash;
  logic [TimeW-1:0]      sel_time;

  assign accept = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Compare the held event against every entry
  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      eq_d[i] = (ent_hash_q[i] == hash_q);
      ok_d[i] = (stamp_q <= ent_time_q[i]) || ((stamp_q - ent_time_q[i]) <= window_q);
    end
  end

  // Find the first equal entry from the front and pick it out
  always_comb begin
    seen     = 1'b0;
    sel_hash = '0;
    sel_time = '0;
    for (int i = 0; i < NumEntries; i++) begin
      upto_first[i] = !seen;
      first_oh[i]   = eq_q[i] && !seen;
      seen          = seen || eq_q[i];
      if (first_oh[i]) begin
        sel_hash = sel_hash | ent_hash_q[i];
        sel_time = sel_time | ent_time_q[i];
      end
    end
  end

  assign hit     = |(first_oh & ok_q);
  assign checked = (level_q >= min_level_q);
  assign dropped = checked && hit;
  assign commit  = (state_q == FrUpd) && (dropped || !full_i);
  assign push_o  = commit && !dropped;

  // Build the command for a forwarded event
  always_comb begin
    push_cmd_o.notice = (skip_q != '0);
    push_cmd_o.count  = skip_q;
    push_cmd_o.hash   = hash_q;
    push_cmd_o.level  = level_q;
    push_cmd_o.stamp  = stamp_q;
  end

  // Sequence compare and update, accept the next event while committing
  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    unique case (state_q)
      FrIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) state_d = FrCmp;
      end
      FrCmp: begin
        state_d = FrUpd;
      end
      FrUpd: begin
        in_i.ready = commit;
        if (commit) state_d = in_i.valid ? FrCmp : FrIdle;
      end
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted event and the compare results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hash_q  <= in_i.message_hash;
      level_q <= in_i.level;
      stamp_q <= in_i.timestamp_us;
    end
    if (state_q == FrCmp) begin
      eq_q <= eq_d;
      ok_q <= ok_d;
    end
  end

  // Write config registers; ignore unknown addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WindowReset;
      min_level_q <= LevelReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.addr))
        CfgWindow:   window_q    <= cfg_i.data[TimeW-1:0];
        CfgMinLevel: min_level_q <= cfg_i.data[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Move the hit entry or the new event to the front, update the skip count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
      for (int i = 0; i < NumEntries; i++) begin
        ent_hash_q[i] <= '0;
        ent_time_q[i] <= '0;
      end
    end else if (commit) begin
      if (checked) begin
        for (int i = 1; i < NumEntries; i++) begin
          if (!hit || upto_first[i]) begin
            ent_hash_q[i] <= ent_hash_q[i-1];
            ent_time_q[i] <= ent_time_q[i-1];
          end
        end
        ent_hash_q[0] <= hit ? sel_hash : hash_q;
        ent_time_q[0] <= hit ? sel_time : stamp_q;
      end
      if (dropped) begin
        if (skip_q != CountMax) skip_q <= skip_q + CountW'(1);
      end else begin
        skip_q <= '0;
      end
    end
  end

endmodule

/* hdl/dsup_back.sv */
// Output sequencer: turns queued commands into result beats, a skip notice first
// where one is due. Depends on dsup_pkg and dsup_if.
module dsup_back import dsup_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  dsup_cmd_t head_i,
  output logic      pop_o,
  dsup_out_if.source out_o
);

  logic              valid_q, valid_d;
  logic              sent_q, sent_d;
  logic              notice_q, notice_d, last_q, last_d;
  logic [CountW-1:0] count_q, count_d;
  logic [HashW-1:0]  hash_q, hash_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [TimeW-1:0]  stamp_q, stamp_d;
  logic              load, want_notice;

  assign load        = !valid_q || out_o.ready;
  assign want_notice = head_i.notice && !sent_q;
  assign pop_o       = load && !empty_i && !want_notice;

  // Pick the next beat from the queue head
  always_comb begin
    valid_d  = valid_q;
    sent_d   = sent_q;
    notice_d = notice_q;
    last_d   = last_q;
    count_d  = count_q;
    hash_d   = hash_q;
    level_d  = level_q;
    stamp_d  = stamp_q;
    if (load) begin
      valid_d = !empty_i;
      stamp_d = head_i.stamp;
      if (want_notice) begin
        sent_d   = !empty_i;
        notice_d = 1'b1;
        last_d   = 1'b0;
        count_d  = head_i.count;
        hash_d   = '0;
        level_d  = NoticeLevel;
      end else begin
        sent_d   = 1'b0;
        notice_d = 1'b0;
        last_d   = 1'b1;
        count_d  = '0;
        hash_d   = head_i.hash;
        level_d  = head_i.level;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sent_q  <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    notice_q <= notice_d;
    last_q   <= last_d;
    count_q  <= count_d;
    hash_q   <= hash_d;
    level_q  <= level_d;
    stamp_q  <= stamp_d;
  end

  assign out_o.valid          = valid_q;
  assign out_o.is_skip_notice = notice_q;
  assign out_o.skipped_count  = count_q;
  assign out_o.out_hash       = hash_q;
  assign out_o.out_level      = level_q;
  assign out_o.out_time_us    = stamp_q;
  assign out_o.last           = last_q;

endmodule

/* hdl/duplicate_event_suppressor.sv */
// Top level of the duplicate event suppressor: classifier, command queue, output sequencer.
// Depends on dsup_pkg, dsup_if, dsup_fifo, dsup_front, dsup_back and the assertion header.
//
// Usage:
//   in_i   event beats: message_hash, level, timestamp_us.
//   cfg_i  register writes: addr 0 window_us, addr 1 min_level; other addresses ignored.
//          Always ready; write only while no event is in flight.
//   out_o  result beats: a skip notice (is_skip_notice=1, last=0) ahead of a forwarded
//          event when suppressed duplicates are pending, then the event (last=1).
//          A duplicate yields no beat at all.
// Flow: each event passes a compare step over all list entries, then an update step that
//   moves an entry to the front; the next event is taken as the update commits.
// Path: event held, compare results registered, command queued on update, then registered
//   into the output beat when free; a pair's event beat loads as its notice is taken.
// Stall: a stalled receiver holds the output beat; the 2-deep command queue lets the
//   classifier go on with events, and dropped duplicates never wait on the output.
// Reset: list entries clear to hash 0 / time 0, skip count to 0, window_us to
//   5000000 and min_level to 4; no clearing pass is needed.
`include "duplicate_event_suppressor_assert.svh"

module duplicate_event_suppressor import dsup_pkg::*; #(
  parameter int unsigned ENTRIES = Entries
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsup_in_if.sink    in_i,
  dsup_cfg_if.sink   cfg_i,
  dsup_out_if.source out_o
);

  logic      push, pop, full, empty;
  dsup_cmd_t push_cmd, head;

  dsup_front #(
    .NumEntries (ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  dsup_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  dsup_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // Queue is never pushed when full nor popped when empty
  `DSUP_ASSERT_NEVER(a_no_overflow, push && full, "command pushed into a full queue")
  `DSUP_ASSERT_NEVER(a_no_underflow, pop && empty, "command popped from an empty queue")
  // An accepted event blocks the input for the compare step
  `DSUP_ASSERT(a_busy_after_accept, (in_i.valid && in_i.ready) |=> !in_i.ready, "input taken during compare")
  // A taken skip notice is followed at once by its event beat
  `DSUP_ASSERT(a_notice_then_event, (out_o.valid && out_o.ready && out_o.is_skip_notice) |=> (out_o.valid && !out_o.is_skip_notice && out_o.last), "skip notice not followed by its event")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for duplicate_event_suppressor: directed and random event streams.
// Predicts every result beat with its own move-to-front list model and checks each beat in order.
// Depends on dsup_pkg, dsup_if and the duplicate_event_suppressor RTL.
module testbench;
  import dsup_pkg::*;

  // Severity codes as seen on the level field
  typedef enum logic [LevelW-1:0] {
    LvTrace, LvDebug, LvInfo, LvWarn, LvError, LvCritical, LvOff, LvSeven
  } level_e;

  // Register indexes that decode to nothing
  localparam logic [CfgAddrW-1:0] CfgSpareLow  = 2'd2;
  localparam logic [CfgAddrW-1:0] CfgSpareHigh = 2'd3;

  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PoolSize    = 16;

  typedef struct packed {
    logic              notice;
    logic [CountW-1:0] count;
    logic [HashW-1:0]  hash;
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  stamp;
    logic              last;
  } beat_t;

  logic clk_i;
  logic rst_ni;

  dsup_in_if  ev_bus ();
  dsup_out_if res_bus ();
  dsup_cfg_if cfg_bus ();

  duplicate_event_suppressor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_bus),
    .cfg_i  (cfg_bus),
    .out_o  (res_bus)
  );

  // Model of the suppressor: recent-event list, drop counter and registers
  logic [HashW-1:0]  list_hash [Entries];
  logic [TimeW-1:0]  list_time [Entries];
  logic [CountW-1:0] dropped_count;
  logic [TimeW-1:0]  window_cfg;
  logic [LevelW-1:0] min_level_cfg;

  beat_t       pending_beats [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          in_gaps_on;
  bit          out_stalls_on;
  logic [TimeW-1:0] stamp_now;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Append one expected beat at the tail
  function automatic void queue_beat(beat_t b);
    pending_beats = {pending_beats, b};
  endfunction

  // Take the oldest expected beat off the head
  function automatic beat_t next_beat();
    beat_t b;
    b = pending_beats[0];
    pending_beats.delete(0);
    return b;
  endfunction

  // Shift entries 0..pos-1 back by one and put entry pos at the front
  function automatic void move_to_front(int pos);
    logic [HashW-1:0] h;
    logic [TimeW-1:0] t;
    h = list_hash[pos];
    t = list_time[pos];
    for (int i = pos; i > 0; i--) begin
      list_hash[i] = list_hash[i-1];
      list_time[i] = list_time[i-1];
    end
    list_hash[0] = h;
    list_time[0] = t;
  endfunction

  // Work out the beats that one accepted event causes and queue them
  function automatic void filter_event(logic [HashW-1:0] h, logic [LevelW-1:0] lv,
                                       logic [TimeW-1:0] ts);
    int    first;
    longint age;
    beat_t b;
    first = -1;
    if (lv >= min_level_cfg) begin
      for (int i = 0; i < Entries; i++) begin
        if (first < 0 && list_hash[i] == h) first = i;
      end
      if (first >= 0) begin
        age = longint'({16'd0, ts}) - longint'({16'd0, list_time[first]});
        if (age <= 0 || age <= longint'({16'd0, window_cfg})) begin
          move_to_front(first);
          if (dropped_count != CountMax) dropped_count++;
          return;
        end
      end
      // Miss or expired match: recycle the oldest entry
      list_hash[Entries-1] = h;
      list_time[Entries-1] = ts;
      move_to_front(Entries - 1);
    end
    if (dropped_count != '0) begin
      b = '{notice: 1'b1, count: dropped_count, hash: '0, level: NoticeLevel,
            stamp: ts, last: 1'b0};
      queue_beat(b);
      dropped_count = '0;
    end
    b = '{notice: 1'b0, count: '0, hash: h, level: lv, stamp: ts, last: 1'b1};
    queue_beat(b);
  endfunction

  // Send one event beat, with an optional idle burst ahead of it
  task automatic send_event(logic [HashW-1:0] h, logic [LevelW-1:0] lv,
                            logic [TimeW-1:0] ts);
    @(negedge clk_i);
    if (in_gaps_on && $urandom_range(0, 2) == 0) begin
      ev_bus.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    ev_bus.valid        = 1'b1;
    ev_bus.message_hash = h;
    ev_bus.level        = lv;
    ev_bus.timestamp_us = ts;
    do @(posedge clk_i); while (!ev_bus.ready);
    filter_event(h, lv, ts);
  endtask

  // Write one register beat; the model only takes indexes that decode
  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.addr  = addr;
    cfg_bus.data  = data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (addr == CfgWindow) window_cfg = data[TimeW-1:0];
    else if (addr == CfgMinLevel) min_level_cfg = data[LevelW-1:0];
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // Hold the input idle until every expected beat is out and a dropped event has retired
  task automatic settle();
    @(negedge clk_i);
    ev_bus.valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Hash zero hits the cleared list right after reset
  task automatic test_zero_hash();
    send_event('0, LvError, '0);
    send_event('0, LvError, 48'd7);
    send_event(64'h1, LvError, 48'd9);
    settle();
  endtask

  // Age equal to the window hits, one past expires, the expired entry stays behind
  task automatic test_window_boundary();
    logic [TimeW-1:0] base;
    base = 48'd20_000_000;
    send_event(64'hA5A5_0000_1111_2222, LvError, base);
    send_event(64'hA5A5_0000_1111_2222, LvError, base + 48'd5_000_000);
    send_event(64'hA5A5_0000_1111_2222, LvCritical, base + 48'd5_000_001);
    send_event(64'hA5A5_0000_1111_2222, LvOff, base + 48'd5_000_001);
    send_event(64'hC0FF_EE00_0000_0003, LvWarn, base + 48'd5_000_002);
    settle();
  endtask

  // A timestamp that goes backwards always counts as a hit
  task automatic test_time_backwards();
    send_event(64'h0BAD_CAFE_0000_0001, LvError, 48'd30_000_000);
    send_event(64'h0BAD_CAFE_0000_0001, LvError, 48'd3);
    settle();
  endtask

  // Low levels bypass the list; level seven is checked like any other
  task automatic test_level_bypass();
    send_event(64'hD00D_0000_0000_0004, LvTrace, 48'd40_000_000);
    send_event(64'hD00D_0000_0000_0004, LvTrace, 48'd40_000_000);
    send_event(64'hD00D_0000_0000_0004, LvSeven, 48'd40_000_001);
    send_event(64'hD00D_0000_0000_0004, LvSeven, 48'd40_000_002);
    settle();
  endtask

  // Toggle every bit of hash and time
  task automatic test_field_extremes();
    send_event('1, LvSeven, '1);
    send_event('1, LvSeven, '0);
    send_event(64'h5555_5555_5555_5555, LvDebug, 48'hAAAA_AAAA_AAAA);
    send_event(64'hAAAA_AAAA_AAAA_AAAA, LvInfo, 48'h5555_5555_5555);
    settle();
  endtask

  // Fill the list with fresh hashes so the first one falls out
  task automatic test_eviction();
    for (int i = 0; i <= Entries; i++) begin
      send_event(64'hE000_0000_0000_0000 | HashW'(i), LvError,
                 48'd50_000_000 + TimeW'(i));
    end
    send_event(64'hE000_0000_0000_0000, LvError, 48'd50_000_100);
    settle();
  endtask

  // Zero window, highest min level and writes to indexes that decode to nothing
  task automatic test_registers();
    write_reg(CfgWindow, '0);
    send_event(64'hF1F1_0000_0000_0005, LvError, 48'd60_000_000);
    send_event(64'hF1F1_0000_0000_0005, LvError, 48'd60_000_000);
    send_event(64'hF1F1_0000_0000_0005, LvError, 48'd60_000_001);
    settle();
    write_reg(CfgMinLevel, 48'hFFFF_FFFF_FFFF);
    write_reg(CfgSpareLow, '0);
    write_reg(CfgSpareHigh, 48'h1234_5678_9ABC);
    send_event(64'hF2F2_0000_0000_0006, LvCritical, 48'd60_000_010);
    send_event(64'hF2F2_0000_0000_0006, LvCritical, 48'd60_000_011);
    send_event(64'hF2F2_0000_0000_0006, LvSeven, 48'd60_000_012);
    send_event(64'hF2F2_0000_0000_0006, LvSeven, 48'd60_000_013);
    settle();
  endtask

  // Mostly repeats from a small hash pool on a rising clock, some noise and backward steps
  task automatic random_events(int unsigned count, int unsigned step_max);
    logic [HashW-1:0]  pool [PoolSize];
    logic [HashW-1:0]  h;
    logic [LevelW-1:0] lv;
    logic [TimeW-1:0]  ts;
    int unsigned       pool_used;
    int unsigned       kind;
    for (int i = 0; i < PoolSize; i++) pool[i] = {$urandom(), $urandom()};
    pool_used = $urandom_range(2, PoolSize);
    stamp_now = TimeW'({$urandom(), $urandom()});
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        in_gaps_on    = $urandom_range(0, 3) != 0;
        out_stalls_on = $urandom_range(0, 3) != 0;
        pool_used     = $urandom_range(2, PoolSize);
      end
      kind = $urandom_range(0, 9);
      lv = ($urandom_range(0, 2) == 0) ? LevelW'($urandom_range(0, 7))
                                       : LevelW'($urandom_range(min_level_cfg, 7));
      if (kind == 0) begin
        h  = {$urandom(), $urandom()};
        ts = TimeW'({$urandom(), $urandom()});
      end else begin
        h = pool[$urandom_range(0, pool_used - 1)];
        if (kind == 1) begin
          ts = stamp_now - TimeW'($urandom_range(0, step_max));
        end else begin
          stamp_now = stamp_now + TimeW'($urandom_range(0, step_max));
          ts = stamp_now;
        end
      end
      send_event(h, lv, ts);
    end
    settle();
  endtask

  // Run through register settings, extremes included
  task automatic test_random_phases();
    logic [TimeW-1:0] w;
    write_reg(CfgWindow, 48'd50);
    write_reg(CfgMinLevel, 48'hFFFF_FFFF_FFF8);
    random_events(350, 30);
    write_reg(CfgWindow, '0);
    write_reg(CfgMinLevel, 48'd3);
    random_events(300, 2);
    write_reg(CfgWindow, 48'hFFFF_FFFF_FFFF);
    write_reg(CfgMinLevel, 48'd7);
    random_events(250, 1000);
    write_reg(CfgWindow, 48'd1000);
    write_reg(CfgMinLevel, 48'd4);
    random_events(300, 600);
    w = TimeW'($urandom_range(0, 2000));
    write_reg(CfgWindow, w);
    write_reg(CfgMinLevel, CfgDataW'($urandom_range(0, 7)));
    random_events(300, 32'(w / 2 + 48'd1));
  endtask

  // Back to reset settings; random_events still switches input gaps and output stalls
  task automatic test_full_rate();
    write_reg(CfgWindow, 48'd5_000_000);
    write_reg(CfgMinLevel, 48'd4);
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    random_events(350, 3_000_000);
  endtask

  // Drive result ready with random stall bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      res_bus.ready = 1'b0;
      stall_left--;
    end else if (out_stalls_on && $urandom_range(0, 4) == 0) begin
      res_bus.ready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      res_bus.ready = 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    beat_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: hash %h level %0d", res_bus.out_hash,
               res_bus.out_level);
        error_count++;
      end else begin
        want = next_beat();
        if (res_bus.is_skip_notice !== want.notice) begin
          $error("is_skip_notice: expected %0d, actual %0d", want.notice,
                 res_bus.is_skip_notice);
          error_count++;
        end
        if (res_bus.skipped_count !== want.count) begin
          $error("skipped_count: expected %0d, actual %0d", want.count,
                 res_bus.skipped_count);
          error_count++;
        end
        if (res_bus.out_hash !== want.hash) begin
          $error("out_hash: expected %h, actual %h", want.hash, res_bus.out_hash);
          error_count++;
        end
        if (res_bus.out_level !== want.level) begin
          $error("out_level: expected %0d, actual %0d", want.level, res_bus.out_level);
          error_count++;
        end
        if (res_bus.out_time_us !== want.stamp) begin
          $error("out_time_us: expected %0d, actual %0d", want.stamp,
                 res_bus.out_time_us);
          error_count++;
        end
        if (res_bus.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, res_bus.last);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    ev_bus.valid        = 1'b0;
    ev_bus.message_hash = '0;
    ev_bus.level        = '0;
    ev_bus.timestamp_us = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.addr        = '0;
    cfg_bus.data        = '0;
    res_bus.ready       = 1'b1;
    stall_left          = 0;
    in_gaps_on          = 1'b1;
    out_stalls_on       = 1'b1;
    error_count         = 0;
    cycle_count         = 0;
    stamp_now           = '0;
    for (int i = 0; i < Entries; i++) begin
      list_hash[i] = '0;
      list_time[i] = '0;
    end
    dropped_count = '0;
    window_cfg    = WindowReset;
    min_level_cfg = LevelReset;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_hash();
    test_window_boundary();
    test_time_backwards();
    test_level_bypass();
    test_field_extremes();
    test_eviction();
    test_registers();
    test_random_phases();
    test_full_rate();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
